// ===== rtl/core/rhn_pkg.sv =====
// Shared types and constants for the RGB histogram normalizer.
// No dependencies; imported by rgb_histogram_normalizer.
package rhn_pkg;

    localparam int BIN_BITS    = 8;
    localparam int NUM_BINS    = 256;
    localparam int HEIGHT_BITS = 8;
    localparam int STEP_BITS   = 3;
    localparam int CH_BITS     = 2;

    // Number of bits gained by the 510 * count scaling
    localparam int SCALE_BITS  = 9;

    // Request codes carried in tuser
    typedef enum logic [1:0] {
        REQ_ACCUM = 2'd0,
        REQ_READ  = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    // Channel selector for the shared unit
    typedef enum logic [CH_BITS-1:0] {
        CH_RED   = 2'd0,
        CH_GREEN = 2'd1,
        CH_BLUE  = 2'd2
    } t_chan;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC_WR,
        S_PEAK,
        S_DIV_LD,
        S_DIV,
        S_OUT,
        S_CLR
    } t_state;

endpackage

// ===== rtl/core/rgb_histogram_normalizer.sv =====
// Top level of the RGB histogram normalizer: three bin memories, peak register
// and one shared subtract/compare unit under a small sequencer. Uses rhn_pkg.
//
// Per-channel 256-bin histogram of 8-bit RGB pixels. Each input transfer carries a
// request kind in tuser: accumulate a pixel, read the scaled heights of one bin, or
// clear. Timing is set by one shared subtractor of COUNT_BITS+9 bits that does the
// peak compares and the restoring division: a pixel passes through the accept, bin
// write-back and one peak compare per channel; a read passes through the accept, per
// channel one numerator load and 8 division steps, and an output state that loads the
// output register, and its result is held there until taken; while an earlier result
// still waits in the output register a read holds in its output state until that
// result is taken. A clear runs the accept and a pass that zeroes one bin address per
// cycle in all three memories; the same pass follows reset before the input side first
// goes ready. The input side is ready only while no request is in work. Heights are
// round(count * 255 / peak) with halves rounded up; bin counts saturate at
// 2^COUNT_BITS - 1, and the peak starts at 1.
module rgb_histogram_normalizer #(
    parameter int COUNT_BITS = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,  // red[7:0], green[15:8], blue[23:16], bin_index[31:24]
    input  logic [1:0]  i_s_tuser,  // req_type[1:0]
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // bin_number[7:0], red_height[15:8], green_height[23:16], blue_height[31:24]
    output logic [31:0] o_m_tdata
);
    import rhn_pkg::*;

    localparam int ALU_BITS = COUNT_BITS + SCALE_BITS;

    // Sequencer state
    t_state r_state, n_state;
    t_chan  r_ch;
    logic [STEP_BITS-1:0] r_step;
    logic [BIN_BITS-1:0]  r_clr_addr;

    // Bin memories
    logic [COUNT_BITS-1:0] r_mem_r [NUM_BINS];
    logic [COUNT_BITS-1:0] r_mem_g [NUM_BINS];
    logic [COUNT_BITS-1:0] r_mem_b [NUM_BINS];

    // Registered read data and addresses
    logic [COUNT_BITS-1:0] r_rdat_r, r_rdat_g, r_rdat_b;
    logic [BIN_BITS-1:0]   r_addr_r, r_addr_g, r_addr_b;
    logic [BIN_BITS-1:0]   r_idx;

    // Datapath registers
    logic [COUNT_BITS-1:0]  r_peak;
    logic [COUNT_BITS-1:0]  r_new_r, r_new_g, r_new_b;
    logic [ALU_BITS-1:0]    r_rem;
    logic [HEIGHT_BITS-1:0] r_q;
    logic [HEIGHT_BITS-1:0] r_h_r, r_h_g, r_h_b;

    // Output register
    logic                  r_m_valid;
    logic [31:0]           r_m_data;

    logic                  w_s_xfer, w_m_xfer, w_out_load;
    t_req                  w_req;
    logic [BIN_BITS-1:0]   w_rd_r, w_rd_g, w_rd_b;
    logic [COUNT_BITS-1:0] w_cnt_r, w_cnt_g, w_cnt_b;
    logic [COUNT_BITS-1:0] w_inc_r, w_inc_g, w_inc_b;
    logic [COUNT_BITS-1:0] w_cnt_sel, w_new_sel;
    logic [ALU_BITS-1:0]   w_num;
    logic [ALU_BITS-1:0]   w_den;
    logic [ALU_BITS-1:0]   w_alu_a, w_alu_b;
    logic [ALU_BITS:0]     w_alu_diff;
    logic                  w_borrow;
    logic [HEIGHT_BITS-1:0] n_q;

    assign w_req    = t_req'(i_s_tuser);
    assign w_s_xfer = i_s_tvalid && o_s_tready;
    assign w_m_xfer = o_m_tvalid && i_m_tready;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    // Load the output register once it is empty or being emptied
    assign w_out_load = (r_state == S_OUT) && (!r_m_valid || i_m_tready);

    // Read addresses: pixel components or the requested bin
    assign w_rd_r = (w_req == REQ_READ) ? i_s_tdata[31:24] : i_s_tdata[7:0];
    assign w_rd_g = (w_req == REQ_READ) ? i_s_tdata[31:24] : i_s_tdata[15:8];
    assign w_rd_b = (w_req == REQ_READ) ? i_s_tdata[31:24] : i_s_tdata[23:16];

    assign w_cnt_r = r_rdat_r;
    assign w_cnt_g = r_rdat_g;
    assign w_cnt_b = r_rdat_b;

    // Saturating increment
    assign w_inc_r = (&w_cnt_r) ? w_cnt_r : w_cnt_r + 1'b1;
    assign w_inc_g = (&w_cnt_g) ? w_cnt_g : w_cnt_g + 1'b1;
    assign w_inc_b = (&w_cnt_b) ? w_cnt_b : w_cnt_b + 1'b1;

    // Select the channel handled by the shared unit
    always_comb begin
        unique case (r_ch)
            CH_RED: begin
                w_cnt_sel = w_cnt_r;
                w_new_sel = r_new_r;
            end
            CH_GREEN: begin
                w_cnt_sel = w_cnt_g;
                w_new_sel = r_new_g;
            end
            CH_BLUE: begin
                w_cnt_sel = w_cnt_b;
                w_new_sel = r_new_b;
            end
            default: begin
                w_cnt_sel = w_cnt_b;
                w_new_sel = r_new_b;
            end
        endcase
    end

    // Numerator 510 * count + peak, divisor 2 * peak shifted to the current step
    assign w_num = ({w_cnt_sel, {SCALE_BITS{1'b0}}}
                  - {{(SCALE_BITS-1){1'b0}}, w_cnt_sel, 1'b0})
                  + {{SCALE_BITS{1'b0}}, r_peak};
    assign w_den = {{(SCALE_BITS-1){1'b0}}, r_peak, 1'b0} << r_step;

    // Shared subtract/compare unit
    always_comb begin
        if (r_state == S_PEAK) begin
            w_alu_a = {{SCALE_BITS{1'b0}}, r_peak};
            w_alu_b = {{SCALE_BITS{1'b0}}, w_new_sel};
        end else begin
            w_alu_a = r_rem;
            w_alu_b = w_den;
        end
    end
    assign w_alu_diff = {1'b0, w_alu_a} - {1'b0, w_alu_b};
    assign w_borrow   = w_alu_diff[ALU_BITS];

    // Quotient with the current bit decided
    always_comb begin
        n_q = r_q;
        if (!w_borrow) begin
            n_q[r_step] = 1'b1;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_s_xfer && w_req == REQ_ACCUM) begin
                    n_state = S_ACC_WR;
                end else if (w_s_xfer && w_req == REQ_READ) begin
                    n_state = S_DIV_LD;
                end else if (w_s_xfer && w_req == REQ_CLEAR) begin
                    n_state = S_CLR;
                end
            end
            S_ACC_WR: n_state = S_PEAK;
            S_PEAK: begin
                if (r_ch == CH_BLUE) begin
                    n_state = S_IDLE;
                end
            end
            S_DIV_LD: n_state = S_DIV;
            S_DIV: begin
                if (r_step == '0) begin
                    n_state = (r_ch == CH_BLUE) ? S_OUT : S_DIV_LD;
                end
            end
            S_OUT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            S_CLR: begin
                if (&r_clr_addr) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register; reset starts with a clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    // Control counters and peak
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch       <= CH_RED;
            r_step     <= '0;
            r_clr_addr <= '0;
            r_peak     <= {{(COUNT_BITS-1){1'b0}}, 1'b1};
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_ch <= CH_RED;
                    if (w_s_xfer && w_req == REQ_CLEAR) begin
                        r_peak     <= {{(COUNT_BITS-1){1'b0}}, 1'b1};
                        r_clr_addr <= '0;
                    end
                end
                S_ACC_WR: ;
                S_PEAK: begin
                    // raise the peak when the new count exceeds it
                    if (w_borrow) begin
                        r_peak <= w_new_sel;
                    end
                    r_ch <= t_chan'(r_ch + 1'b1);
                end
                S_DIV_LD: begin
                    r_step <= STEP_BITS'(HEIGHT_BITS - 1);
                end
                S_DIV: begin
                    if (r_step == '0) begin
                        r_ch <= t_chan'(r_ch + 1'b1);
                    end else begin
                        r_step <= r_step - 1'b1;
                    end
                end
                S_OUT: ;
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Output register: hold a result until its transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_out_load) begin
            r_m_valid <= 1'b1;
        end else if (w_m_xfer) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_m_data <= {r_h_b, r_h_g, r_h_r, r_idx};
        end
    end

    // Bin memories: read on input transfer, write back in the update cycle,
    // zero one address per cycle during a clearing pass
    always_ff @(posedge i_clk) begin
        if (w_s_xfer) begin
            r_rdat_r <= r_mem_r[w_rd_r];
            r_rdat_g <= r_mem_g[w_rd_g];
            r_rdat_b <= r_mem_b[w_rd_b];
            r_addr_r <= w_rd_r;
            r_addr_g <= w_rd_g;
            r_addr_b <= w_rd_b;
            r_idx    <= i_s_tdata[31:24];
        end
        if (r_state == S_ACC_WR) begin
            r_mem_r[r_addr_r] <= w_inc_r;
            r_mem_g[r_addr_g] <= w_inc_g;
            r_mem_b[r_addr_b] <= w_inc_b;
        end else if (r_state == S_CLR) begin
            r_mem_r[r_clr_addr] <= '0;
            r_mem_g[r_clr_addr] <= '0;
            r_mem_b[r_clr_addr] <= '0;
        end
    end

    // Payload: new counts, division remainder, quotient and heights
    always_ff @(posedge i_clk) begin
        if (r_state == S_ACC_WR) begin
            r_new_r <= w_inc_r;
            r_new_g <= w_inc_g;
            r_new_b <= w_inc_b;
        end
        if (r_state == S_DIV_LD) begin
            r_rem <= w_num;
            r_q   <= '0;
        end
        if (r_state == S_DIV) begin
            // keep the trial remainder when the shifted divisor fits
            if (!w_borrow) begin
                r_rem <= w_alu_diff[ALU_BITS-1:0];
            end
            r_q <= n_q;
            if (r_step == '0) begin
                unique case (r_ch)
                    CH_RED:   r_h_r <= n_q;
                    CH_GREEN: r_h_g <= n_q;
                    CH_BLUE:  r_h_b <= n_q;
                    default:  r_h_b <= n_q;
                endcase
            end
        end
    end

endmodule
